// ----- rtl/mavas_pkg.sv -----
// ----------------------------------------------------------------------------
// mavas_pkg
// Fixed widths, register indexes and reset values of the moving average
// angle scaler.
// ----------------------------------------------------------------------------
package mavas_pkg;

    localparam int MEAN_W     = 10;
    localparam int ANGLE_W    = 8;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_IN_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 2'd2;

    localparam logic [LIMIT_W-1:0] IN_LOW_RESET   = 10'd277;
    localparam logic [LIMIT_W-1:0] IN_HIGH_RESET  = 10'd413;
    localparam logic [ANGLE_W-1:0] OUT_HIGH_RESET = 8'd180;

endpackage

// ----- rtl/moving_average_angle_scaler.sv -----
// ----------------------------------------------------------------------------
// moving_average_angle_scaler
// Window mean of incoming samples and its linear map onto a clamped angle,
// with a reciprocal multiply for the mean and one restoring divider
// for the angle scaling.
//
//   channel  dir  ports                                   transfer when
//   s_       in   s_valid s_ready s_sample                s_valid & s_ready
//   m_       out  m_valid m_ready m_mean_raw m_angle      m_valid & m_ready
//   cfg_     in   cfg_valid cfg_ready cfg_index cfg_data  cfg_valid & cfg_ready
//
// After its transfer a sample runs through sum update, mean, range check,
// product, PROD_W divider steps and output load; the block then returns to
// idle, the only state in which it takes the next sample. An angle that is
// zero by range skips the product and the division.
// Reset is synchronous on aresetn; per-entry valid bits make the ring read as
// zero. A result waiting on m_ready holds only the output load step.
// ----------------------------------------------------------------------------
module moving_average_angle_scaler #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SAMPLE_BITS-1:0]            s_sample,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mavas_pkg::MEAN_W-1:0]      m_mean_raw,
    output logic [mavas_pkg::ANGLE_W-1:0]     m_angle,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mavas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mavas_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
    localparam int OPW      = (SAMPLE_BITS > mavas_pkg::LIMIT_W) ? SAMPLE_BITS
                                                                  : mavas_pkg::LIMIT_W;
    localparam int PROD_W   = OPW + mavas_pkg::ANGLE_W;
    localparam int DIV_W    = PROD_W;
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int RECIP_SH = SUM_W + IDX_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int MPROD_W  = SUM_W + RECIP_W;

    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(WINDOW - 1);
    localparam logic [RECIP_W-1:0] RECIP    =
        RECIP_W'(((1 << RECIP_SH) + WINDOW - 1) / WINDOW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_MEAN = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DIV2 = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [SAMPLE_BITS-1:0]         sample_reg, sample_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [WINDOW-1:0]              valid_reg, valid_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [DIV_W-1:0]               rem_reg, rem_next;
    logic [DIV_W-1:0]               quo_reg, quo_next;
    logic [DIV_W-1:0]               den_reg, den_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]         mean_reg, mean_next;
    logic [OPW-1:0]                 diff_reg, diff_next;
    logic [mavas_pkg::ANGLE_W-1:0]  angle_reg, angle_next;
    logic                           m_valid_reg, m_valid_next;
    logic [mavas_pkg::MEAN_W-1:0]   m_mean_reg, m_mean_next;
    logic [mavas_pkg::ANGLE_W-1:0]  m_angle_reg, m_angle_next;
    logic [mavas_pkg::LIMIT_W-1:0]  in_low_reg, in_low_next;
    logic [mavas_pkg::LIMIT_W-1:0]  in_high_reg, in_high_next;
    logic [mavas_pkg::ANGLE_W-1:0]  out_high_reg, out_high_next;

    logic [SAMPLE_BITS-1:0]         ring_mem [WINDOW];
    logic [SAMPLE_BITS-1:0]         rd_data_reg;

    logic [SAMPLE_BITS-1:0]         old_sample;
    logic [SUM_W-1:0]               sum_upd;
    logic [DIV_W:0]                 trial;
    logic [DIV_W:0]                 trial_sub;
    logic                           trial_ge;
    logic [DIV_W-1:0]               rem_step;
    logic [DIV_W-1:0]               quo_step;
    logic [MPROD_W-1:0]             mean_prod;
    logic [SAMPLE_BITS-1:0]         mean_q;
    logic [OPW-1:0]                 mean_ext;
    logic [OPW-1:0]                 low_ext;
    logic                           angle_zero;
    logic [PROD_W-1:0]              prod;
    logic                           out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_mean_raw = m_mean_reg;
    assign m_angle    = m_angle_reg;

    // ring storage, read every cycle at the write index
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            ring_mem[idx_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[idx_reg];
    end

    always_comb begin
        old_sample = valid_reg[idx_reg] ? rd_data_reg : '0;
        sum_upd    = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);

        trial     = {rem_reg, quo_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        trial_ge  = (trial >= {1'b0, den_reg});
        rem_step  = trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_step  = {quo_reg[DIV_W-2:0], trial_ge};

        mean_prod  = MPROD_W'(sum_reg) * MPROD_W'(RECIP);
        mean_q     = mean_prod[RECIP_SH +: SAMPLE_BITS];
        mean_ext   = OPW'(mean_reg);
        low_ext    = OPW'(in_low_reg);
        angle_zero = (in_high_reg <= in_low_reg) || (mean_ext <= low_ext);
        prod       = PROD_W'(diff_reg) * PROD_W'(out_high_reg);
        out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        sum_next      = sum_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        cnt_next      = cnt_reg;
        mean_next     = mean_reg;
        diff_next     = diff_reg;
        angle_next    = angle_reg;
        m_valid_next  = m_valid_reg;
        m_mean_next   = m_mean_reg;
        m_angle_next  = m_angle_reg;
        in_low_next   = in_low_reg;
        in_high_next  = in_high_reg;
        out_high_next = out_high_reg;

        if (cfg_valid) begin
            case (cfg_index)
                mavas_pkg::REG_IN_LOW:   in_low_next   = cfg_data;
                mavas_pkg::REG_IN_HIGH:  in_high_next  = cfg_data;
                mavas_pkg::REG_OUT_HIGH: out_high_next = cfg_data[mavas_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM: begin
                // drop the oldest entry, add the new one, advance with wrap
                sum_next            = sum_upd;
                valid_next[idx_reg] = 1'b1;
                idx_next            = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                state_next          = ST_MEAN;
            end
            ST_MEAN: begin
                mean_next  = mean_q;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                diff_next = mean_ext - low_ext;
                if (angle_zero) begin
                    angle_next = '0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                rem_next   = '0;
                quo_next   = DIV_W'(prod);
                den_next   = DIV_W'(in_high_reg - in_low_reg);
                cnt_next   = CNT_W'(PROD_W);
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    if (quo_step > DIV_W'(out_high_reg)) begin
                        angle_next = out_high_reg;
                    end else begin
                        angle_next = quo_step[mavas_pkg::ANGLE_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_mean_next  = mavas_pkg::MEAN_W'(mean_reg);
                    m_angle_next = angle_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            valid_reg    <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
            in_low_reg   <= mavas_pkg::IN_LOW_RESET;
            in_high_reg  <= mavas_pkg::IN_HIGH_RESET;
            out_high_reg <= mavas_pkg::OUT_HIGH_RESET;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            sum_reg      <= sum_next;
            m_valid_reg  <= m_valid_next;
            in_low_reg   <= in_low_next;
            in_high_reg  <= in_high_next;
            out_high_reg <= out_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        den_reg     <= den_next;
        cnt_reg     <= cnt_next;
        mean_reg    <= mean_next;
        diff_reg    <= diff_next;
        angle_reg   <= angle_next;
        m_mean_reg  <= m_mean_next;
        m_angle_reg <= m_angle_next;
    end

endmodule
